// ===== sv/sdfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfb_pkg
// Shared types and constants of the scrolling delta frame buffer.
// ----------------------------------------------------------------------------
package sdfb_pkg;

  localparam int KIND_W       = 3;
  localparam int ADDR_FIELD_W = 12;
  localparam int BYTE_W       = 8;
  localparam int COL_W        = 7;
  localparam int ROW_W        = 6;
  localparam int PAN_W        = 10;
  localparam int IMG_W        = 10;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 10;
  // column plus pan offset
  localparam int XW           = 11;
  localparam int MOD_CNT_W    = 4;

  localparam logic [BYTE_W-1:0] PIX_MASK = 8'h80;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_CLEAR = 3'd0;
  localparam kind_t KIND_WRITE = 3'd1;
  localparam kind_t KIND_XOR   = 3'd2;
  localparam kind_t KIND_TICK  = 3'd3;
  localparam kind_t KIND_READ  = 3'd4;

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_BOUNCE     = 2'd0;
  localparam mode_t MODE_WRAP_RIGHT = 2'd1;
  localparam mode_t MODE_WRAP_LEFT  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_IMAGE_WIDTH = 1'd0;
  localparam reg_idx_t REG_PAN_MODE    = 1'd1;

  typedef struct packed {
    logic load_req;
    logic sweep_start;
    logic sweep_write;
    logic mem_write_item;
    logic xor_write;
    logic pan_tick;
    logic pan_clear;
    logic res_load_now;
    logic mod_step;
    logic addr_calc;
    logic fetch;
    logic res_load_pixel;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic mod_last;
    logic wrap_mode;
    logic width_zero;
    logic res_free;
  } dp_status_t;

endpackage

// ===== sv/sdfb_if.sv =====
// ----------------------------------------------------------------------------
// sdfb_if
// Request and result channels of the scrolling delta frame buffer.
// ----------------------------------------------------------------------------
interface sdfb_req_if import sdfb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  kind_t                   kind;
  logic [ADDR_FIELD_W-1:0] byte_addr;
  logic [BYTE_W-1:0]       byte_value;
  logic [COL_W-1:0]        column;
  logic [ROW_W-1:0]        row;

  modport source (output valid, kind, byte_addr, byte_value, column, row, input ready);
  modport sink (input valid, kind, byte_addr, byte_value, column, row, output ready);
endinterface

interface sdfb_res_if import sdfb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pixel_on;
  logic [PAN_W-1:0] pan_position;
  logic             panning_left;

  modport source (output valid, pixel_on, pan_position, panning_left, input ready);
  modport sink (input valid, pixel_on, pan_position, panning_left, output ready);
endinterface

// ===== sv/sdfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdfb_ctrl
// Request sequencer: store sweep, read-modify-write and pixel read steps.
// ----------------------------------------------------------------------------
module sdfb_ctrl import sdfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  kind_t      req_kind,
  output logic       req_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_XOR_WR,
    S_MOD,
    S_ADDR,
    S_FETCH,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == S_IDLE) && status.res_free;
    accept     = req_valid && req_ready;
    case (state)
      S_SWEEP: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          case (req_kind)
            KIND_CLEAR: begin
              cmd.pan_clear    = 1'b1;
              cmd.res_load_now = 1'b1;
              cmd.sweep_start  = 1'b1;
              state_next       = S_SWEEP;
            end
            KIND_WRITE: begin
              cmd.mem_write_item = 1'b1;
              cmd.res_load_now   = 1'b1;
            end
            KIND_XOR: begin
              cmd.res_load_now = 1'b1;
              state_next       = S_XOR_WR;
            end
            KIND_TICK: begin
              cmd.pan_tick     = 1'b1;
              cmd.res_load_now = 1'b1;
            end
            KIND_READ: begin
              if (status.wrap_mode) begin
                if (status.width_zero) begin
                  cmd.res_load_now = 1'b1;
                end else begin
                  state_next = S_MOD;
                end
              end else begin
                state_next = S_ADDR;
              end
            end
            default: begin
              cmd.res_load_now = 1'b1;
            end
          endcase
        end
      end
      S_XOR_WR: begin
        cmd.xor_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr_calc = 1'b1;
        state_next    = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.res_load_pixel = 1'b1;
        state_next         = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/sdfb_datapath.sv =====
// ----------------------------------------------------------------------------
// sdfb_datapath
// Frame store, pan state, modulo unit, pixel addressing and result register.
// ----------------------------------------------------------------------------
module sdfb_datapath import sdfb_pkg::*; #(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64,
  parameter int STORE_BYTES = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic                    cfg_write_en,
  input  reg_idx_t                cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [ADDR_FIELD_W-1:0] byte_addr,
  input  logic [BYTE_W-1:0]       byte_value,
  input  logic [COL_W-1:0]        column,
  input  logic [ROW_W-1:0]        row,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic                    res_pixel,
  output logic [PAN_W-1:0]        res_pan,
  output logic                    res_left
);

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int LIN_W  = XW + $clog2(DISP_HEIGHT) + 1;
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_BYTES - 1);
  localparam logic [XW-1:0]     DW_V       = XW'(DISP_WIDTH);

  // configuration
  logic [IMG_W-1:0] image_width;
  mode_t            pan_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= '0;
      pan_mode    <= MODE_BOUNCE;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: image_width <= cfg_data[IMG_W-1:0];
        REG_PAN_MODE:    pan_mode    <= cfg_data[MODE_W-1:0];
        default:         ;
      endcase
    end
  end

  logic wrap_mode;
  assign wrap_mode = pan_mode inside {MODE_WRAP_RIGHT, MODE_WRAP_LEFT};

  // pan state
  logic [PAN_W-1:0] pan_offset;
  logic [PAN_W-1:0] pan_offset_next;
  logic             pan_left;
  logic             pan_left_next;
  logic [XW-1:0]    vw;
  logic [PAN_W-1:0] end_pos;
  logic [PAN_W-1:0] right_reset;
  logic             can_move;

  assign vw          = wrap_mode ? {image_width, 1'b0} : {1'b0, image_width};
  assign can_move    = vw > DW_V;
  assign end_pos     = PAN_W'(vw - DW_V);
  assign right_reset = PAN_W'(vw - DW_V - {1'b0, image_width});

  always_comb begin
    pan_offset_next = pan_offset;
    pan_left_next   = pan_left;
    if (cmd.pan_clear) begin
      pan_offset_next = '0;
      pan_left_next   = (pan_mode == MODE_WRAP_LEFT);
    end else if (cmd.pan_tick && can_move) begin
      if (!pan_left) begin
        if (pan_offset == end_pos) begin
          if (pan_mode == MODE_WRAP_RIGHT) begin
            pan_offset_next = right_reset;
          end else begin
            pan_left_next = 1'b1;
          end
        end else begin
          pan_offset_next = pan_offset + 1'b1;
        end
      end else begin
        if (pan_offset == '0) begin
          if (pan_mode == MODE_WRAP_LEFT) begin
            pan_offset_next = image_width;
          end else begin
            pan_left_next = 1'b0;
          end
        end else begin
          pan_offset_next = pan_offset - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_offset <= '0;
      pan_left   <= 1'b0;
    end else begin
      pan_offset <= pan_offset_next;
      pan_left   <= pan_left_next;
    end
  end

  // request capture
  logic [31:0]       addr_ext;
  logic              addr_ok;
  logic [ADDR_W-1:0] addr_q;
  logic              addr_ok_q;
  logic [BYTE_W-1:0] value_q;
  logic [ROW_W-1:0]  row_q;

  assign addr_ext = 32'(byte_addr);
  assign addr_ok  = addr_ext < 32'(STORE_BYTES);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      addr_q    <= addr_ext[ADDR_W-1:0];
      addr_ok_q <= addr_ok;
      value_q   <= byte_value;
      row_q     <= row;
    end
  end

  // remainder unit, one quotient bit per cycle
  logic [XW-1:0]        x;
  logic [IMG_W-1:0]     rem;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [IMG_W:0]       trial;

  assign trial = {rem, x[XW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      x       <= XW'(column) + XW'(pan_offset);
      rem     <= '0;
      mod_cnt <= MOD_CNT_W'(XW - 1);
    end else if (cmd.mod_step) begin
      x       <= x << 1;
      mod_cnt <= mod_cnt - 1'b1;
      if (trial >= {1'b0, image_width}) begin
        rem <= IMG_W'(trial - {1'b0, image_width});
      end else begin
        rem <= trial[IMG_W-1:0];
      end
    end
  end

  // pixel addressing
  logic [XW-1:0]    xsel;
  logic [LIN_W-1:0] lin;
  logic [31:0]      b_ext;
  logic             in_range;
  logic [2:0]       bit_sel;

  assign xsel  = wrap_mode ? {1'b0, rem} : x;
  assign b_ext = 32'(lin >> 3);

  always_ff @(posedge clk) begin
    if (cmd.addr_calc) begin
      lin <= LIN_W'(32'(DISP_HEIGHT) * 32'(xsel)) + LIN_W'(row_q);
    end
    if (cmd.fetch) begin
      in_range <= b_ext < 32'(STORE_BYTES);
      bit_sel  <= lin[2:0];
    end
  end

  // frame store
  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [ADDR_W-1:0] sweep_cnt;

  assign rd_addr = cmd.fetch ? b_ext[ADDR_W-1:0] : addr_ext[ADDR_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep_cnt;
    wr_data = '0;
    if (cmd.sweep_write) begin
      wr_en = 1'b1;
    end else if (cmd.mem_write_item) begin
      wr_en   = addr_ok;
      wr_addr = addr_ext[ADDR_W-1:0];
      wr_data = byte_value;
    end else if (cmd.xor_write) begin
      wr_en   = addr_ok_q;
      wr_addr = addr_q;
      wr_data = rd_data ^ value_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_start) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_write) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load_now || cmd.res_load_pixel) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load_now) begin
      res_pixel <= 1'b0;
      res_pan   <= pan_offset_next;
      res_left  <= pan_left_next;
    end else if (cmd.res_load_pixel) begin
      res_pixel <= in_range && ((rd_data & (PIX_MASK >> bit_sel)) != '0);
      res_pan   <= pan_offset;
      res_left  <= pan_left;
    end
  end

  assign status.sweep_last = (sweep_cnt == SWEEP_LAST);
  assign status.mod_last   = (mod_cnt == '0);
  assign status.wrap_mode  = wrap_mode;
  assign status.width_zero = (image_width == '0);
  assign status.res_free   = !res_valid || res_ready;

endmodule

// ===== sv/scrolling_delta_frame_buffer.sv =====
// result is registered on accepting a clear, write, xor, tick or unused-kind request
// an xor holds the next request off through its write-back state (read-modify-write of the store)
// a pixel read steps through S_ADDR, S_FETCH and S_DONE, after S_MOD in the wrap modes (one remainder bit per cycle)
// a clear sweeps the store one byte per cycle and takes no request until the sweep ends
// after reset the same sweep runs with req.ready low
// ----------------------------------------------------------------------------
// scrolling_delta_frame_buffer
// 1-bit frame store with byte write, xor delta and panned pixel readout.
// ----------------------------------------------------------------------------
module scrolling_delta_frame_buffer import sdfb_pkg::*; #(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64,
  parameter int STORE_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  sdfb_req_if.sink              req,
  sdfb_res_if.source            rsp,
  input  logic                  cfg_write_en,
  input  reg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       req_ready;

  assign req.ready = req_ready;

  sdfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sdfb_datapath #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT),
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_addr    (req.byte_addr),
    .byte_value   (req.byte_value),
    .column       (req.column),
    .row          (req.row),
    .res_valid    (rsp.valid),
    .res_ready    (rsp.ready),
    .res_pixel    (rsp.pixel_on),
    .res_pan      (rsp.pan_position),
    .res_left     (rsp.panning_left)
  );

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.kind == KIND_CLEAR |=> !req.ready)
    else $error("request taken during store sweep");

  a_xor_blocks: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.kind == KIND_XOR |=> !req.ready)
    else $error("request taken during xor write-back");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.kind == KIND_WRITE |=> rsp.valid)
    else $error("write request gave no result");
`endif

endmodule
